>>> sv/bda_pkg.sv
// Package for the button debounce and auto-repeat core.
// Holds the configuration register type, register indexes and reset values.
// Used by bda_button and button_debounce_autorepeat_core.
package bda_pkg;

    // Default width of the hold timer and the interval counter.
    localparam int TIMER_WIDTH_DEF = 16;

    // Width of the configuration index and data.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_INTERVAL  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_ONE_START   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_TWO_START   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_THREE_START = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_ONE      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_TWO      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_THREE    = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEBOUNCE_TICKS_RST    = 8'd15;
    localparam logic [15:0] INITIAL_INTERVAL_RST  = 16'd150;
    localparam logic [15:0] STAGE_ONE_START_RST   = 16'd500;
    localparam logic [15:0] STAGE_TWO_START_RST   = 16'd1250;
    localparam logic [15:0] STAGE_THREE_START_RST = 16'd2500;
    localparam logic [15:0] INTERVAL_ONE_RST      = 16'd125;
    localparam logic [15:0] INTERVAL_TWO_RST      = 16'd83;
    localparam logic [15:0] INTERVAL_THREE_RST    = 16'd62;

    // Configuration register set shared by all button slots.
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] initial_interval;
        logic [15:0] stage_one_start;
        logic [15:0] stage_two_start;
        logic [15:0] stage_three_start;
        logic [15:0] interval_one;
        logic [15:0] interval_two;
        logic [15:0] interval_three;
    } bda_cfg_t;

    localparam bda_cfg_t CFG_RST = '{
        debounce_ticks:    DEBOUNCE_TICKS_RST,
        initial_interval:  INITIAL_INTERVAL_RST,
        stage_one_start:   STAGE_ONE_START_RST,
        stage_two_start:   STAGE_TWO_START_RST,
        stage_three_start: STAGE_THREE_START_RST,
        interval_one:      INTERVAL_ONE_RST,
        interval_two:      INTERVAL_TWO_RST,
        interval_three:    INTERVAL_THREE_RST
    };

    // Input item as held in the input register.
    typedef struct packed {
        logic pin_inc;
        logic pin_dec;
        logic pin_mode;
        logic clear_inc;
        logic clear_dec;
        logic clear_mode;
    } bda_item_t;

endpackage

>>> sv/bda_button.sv
// One button slot: debounce run counters, hold timer, repeat interval
// selection and interval counter. State advances by one tick when step is high.
// Depends on bda_pkg.
module bda_button #(
    parameter int TIMER_WIDTH = bda_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   level,
    input  logic                   clear,
    input  logic                   accel,
    input  bda_pkg::bda_cfg_t      cfg,
    output logic                   pressed,
    output logic                   ready,
    output logic [TIMER_WIDTH-1:0] hold
);
    import bda_pkg::*;

    // Common width for comparing timers against 16-bit settings.
    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    logic [7:0]             low_run_reg, low_run_next;
    logic [7:0]             high_run_reg, high_run_next;
    logic                   pressed_reg, pressed_next;
    logic [TIMER_WIDTH-1:0] hold_reg, hold_next;
    logic [15:0]            interval_reg, interval_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic                   ready_reg, ready_next;

    logic                   ready_cleared;
    logic [CMP_W-1:0]       hold_cmp;
    logic [TIMER_WIDTH-1:0] count_inc;

    // One tick of the slot, in the order debounce, hold, interval count.
    always_comb
    begin
        low_run_next  = low_run_reg;
        high_run_next = high_run_reg;
        pressed_next  = pressed_reg;
        hold_next     = hold_reg;
        interval_next = interval_reg;
        count_next    = count_reg;
        ready_cleared = ready_reg & ~clear;
        ready_next    = ready_cleared;
        count_inc     = count_reg + 1'b1;

        // Debounce with saturating run counters.
        if (level == 1'b0)
        begin
            low_run_next  = (low_run_reg != 8'hFF) ? low_run_reg + 8'd1 : low_run_reg;
            high_run_next = 8'd0;
            if (low_run_next >= cfg.debounce_ticks)
            begin
                pressed_next = 1'b1;
            end
        end
        else
        begin
            high_run_next = (high_run_reg != 8'hFF) ? high_run_reg + 8'd1 : high_run_reg;
            low_run_next  = 8'd0;
            if (high_run_next >= cfg.debounce_ticks)
            begin
                pressed_next  = 1'b0;
                hold_next     = '0;
                interval_next = cfg.initial_interval;
            end
        end

        // Hold timer and interval acceleration while pressed.
        if (pressed_next)
        begin
            if (hold_next != {TIMER_WIDTH{1'b1}})
            begin
                hold_next = hold_next + 1'b1;
            end
        end
        hold_cmp = CMP_W'(hold_next);
        if (pressed_next && accel)
        begin
            priority if (hold_cmp > CMP_W'(cfg.stage_one_start)
                         && hold_cmp < CMP_W'(cfg.stage_two_start))
            begin
                interval_next = cfg.interval_one;
            end
            else if (hold_cmp >= CMP_W'(cfg.stage_two_start)
                     && hold_cmp < CMP_W'(cfg.stage_three_start))
            begin
                interval_next = cfg.interval_two;
            end
            else if (hold_cmp >= CMP_W'(cfg.stage_three_start))
            begin
                interval_next = cfg.interval_three;
            end
            else
            begin
                interval_next = interval_next;
            end
        end

        // Interval counter runs while the ready flag is clear.
        if (!ready_cleared)
        begin
            if (CMP_W'(count_inc) >= CMP_W'(interval_next))
            begin
                count_next = '0;
                ready_next = 1'b1;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    // Slot state registers; they also hold the latest result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_run_reg  <= 8'd0;
            high_run_reg <= 8'd0;
            pressed_reg  <= 1'b0;
            hold_reg     <= '0;
            interval_reg <= INITIAL_INTERVAL_RST;
            count_reg    <= '0;
            ready_reg    <= 1'b0;
        end
        else if (step)
        begin
            low_run_reg  <= low_run_next;
            high_run_reg <= high_run_next;
            pressed_reg  <= pressed_next;
            hold_reg     <= hold_next;
            interval_reg <= interval_next;
            count_reg    <= count_next;
            ready_reg    <= ready_next;
        end
    end

    assign pressed = pressed_reg;
    assign ready   = ready_reg;
    assign hold    = hold_reg;

endmodule

>>> sv/button_debounce_autorepeat_core.sv
// Top level of the button debounce and auto-repeat core.
// Holds the configuration registers, the input register and the output valid.
// Depends on bda_pkg and bda_button.
//
//  Channel   Handshake                Payload
//  --------  -----------------------  -------------------------------------------
//  input     in_valid / in_ready      pin_inc pin_dec pin_mode clear_inc/dec/mode
//  result    out_valid / out_ready    pressed_* ready_* mode_hold_ticks
//  config    cfg_valid / cfg_ready    cfg_index cfg_data
//
// Each tick passes through the input register, then through the slot update logic
// into the slot state registers, which drive the result.
// A new tick is accepted every cycle while the result side keeps up.
// Reset zeroes slot state, presets intervals and loads the configuration defaults.
// A stalled result holds the slot state; the input register then holds one more tick.
module button_debounce_autorepeat_core #(
    parameter int TIMER_WIDTH = bda_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             pin_inc,
    input  logic                             pin_dec,
    input  logic                             pin_mode,
    input  logic                             clear_inc,
    input  logic                             clear_dec,
    input  logic                             clear_mode,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pressed_inc,
    output logic                             pressed_dec,
    output logic                             pressed_mode,
    output logic                             ready_inc,
    output logic                             ready_dec,
    output logic                             ready_mode,
    output logic [15:0]                      mode_hold_ticks,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bda_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bda_pkg::*;

    bda_cfg_t               cfg_reg;
    bda_item_t              item_reg;
    logic                   item_valid_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   step;
    logic [TIMER_WIDTH-1:0] hold_inc, hold_dec, hold_mode;

    // The slot state moves on when the result slot is free or being taken.
    assign advance   = !out_valid_reg || out_ready;
    assign step      = item_valid_reg && advance;
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:    cfg_reg.debounce_ticks    <= cfg_data[7:0];
                REG_INITIAL_INTERVAL:  cfg_reg.initial_interval  <= cfg_data;
                REG_STAGE_ONE_START:   cfg_reg.stage_one_start   <= cfg_data;
                REG_STAGE_TWO_START:   cfg_reg.stage_two_start   <= cfg_data;
                REG_STAGE_THREE_START: cfg_reg.stage_three_start <= cfg_data;
                REG_INTERVAL_ONE:      cfg_reg.interval_one      <= cfg_data;
                REG_INTERVAL_TWO:      cfg_reg.interval_two      <= cfg_data;
                REG_INTERVAL_THREE:    cfg_reg.interval_three    <= cfg_data;
            endcase
        end
    end

    // Input register valid and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{
                pin_inc:    pin_inc,
                pin_dec:    pin_dec,
                pin_mode:   pin_mode,
                clear_inc:  clear_inc,
                clear_dec:  clear_dec,
                clear_mode: clear_mode
            };
        end
    end

    // Pins are cross-wired: pin_mode feeds the increment slot and pin_inc
    // feeds the mode slot. The mode slot never accelerates.
    bda_button #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_slot_inc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (item_reg.pin_mode),
        .clear   (item_reg.clear_inc),
        .accel   (1'b1),
        .cfg     (cfg_reg),
        .pressed (pressed_inc),
        .ready   (ready_inc),
        .hold    (hold_inc)
    );

    bda_button #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_slot_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (item_reg.pin_dec),
        .clear   (item_reg.clear_dec),
        .accel   (1'b1),
        .cfg     (cfg_reg),
        .pressed (pressed_dec),
        .ready   (ready_dec),
        .hold    (hold_dec)
    );

    bda_button #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_slot_mode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (item_reg.pin_inc),
        .clear   (item_reg.clear_mode),
        .accel   (1'b0),
        .cfg     (cfg_reg),
        .pressed (pressed_mode),
        .ready   (ready_mode),
        .hold    (hold_mode)
    );

    // Only the mode slot's hold time is reported; the others stay internal.
    assign mode_hold_ticks = 16'(hold_mode);
    assign out_valid       = out_valid_reg;

    logic unused_hold;
    assign unused_hold = ^{hold_inc, hold_dec};

endmodule

>>> dv/bda_tick_checker.sv
`timescale 1ns / 1ps
// Scoreboard for button_debounce_autorepeat_core: watches the tick, status and
// register channels, predicts every status transfer and compares it by field.
// Depends on bda_pkg for the register indexes, the register set and its reset values.
module bda_tick_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            pin_inc,
    input  logic                            pin_dec,
    input  logic                            pin_mode,
    input  logic                            clear_inc,
    input  logic                            clear_dec,
    input  logic                            clear_mode,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            pressed_inc,
    input  logic                            pressed_dec,
    input  logic                            pressed_mode,
    input  logic                            ready_inc,
    input  logic                            ready_dec,
    input  logic                            ready_mode,
    input  logic [15:0]                     mode_hold_ticks,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              pending,
    output int                              fail_count
);
    import bda_pkg::*;

    // Button slots as seen on the status outputs.
    localparam int SLOT_INC  = 0;
    localparam int SLOT_DEC  = 1;
    localparam int SLOT_MODE = 2;
    localparam int MAX_REPORTS = 10;
    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    typedef struct packed {
        logic        pressed_inc;
        logic        pressed_dec;
        logic        pressed_mode;
        logic        ready_inc;
        logic        ready_dec;
        logic        ready_mode;
        logic [15:0] mode_hold_ticks;
    } button_status_t;

    // Shadow of the register set and of the per-slot state.
    bda_cfg_t    cfg_shadow;
    logic [7:0]  low_run_cnt  [3];
    logic [7:0]  high_run_cnt [3];
    logic        is_pressed   [3];
    logic [15:0] hold_ticks   [3];
    logic [15:0] repeat_ticks [3];
    logic [15:0] interval_cnt [3];
    logic        repeat_due   [3];

    button_status_t predicted_status_q[$];
    int n_fail = 0;
    int n_status = 0;

    // One tick of one slot: debounce, hold timer with interval choice, repeat counter.
    task automatic advance_button(input int s, input logic level, input logic speeds_up);
        logic [15:0] held;
        if (!level) begin
            if (low_run_cnt[s] != 8'hFF) low_run_cnt[s] = low_run_cnt[s] + 8'd1;
            high_run_cnt[s] = 8'd0;
            if (low_run_cnt[s] >= cfg_shadow.debounce_ticks) is_pressed[s] = 1'b1;
        end else begin
            if (high_run_cnt[s] != 8'hFF) high_run_cnt[s] = high_run_cnt[s] + 8'd1;
            low_run_cnt[s] = 8'd0;
            if (high_run_cnt[s] >= cfg_shadow.debounce_ticks) begin
                is_pressed[s]   = 1'b0;
                hold_ticks[s]   = 16'd0;
                repeat_ticks[s] = cfg_shadow.initial_interval;
            end
        end

        if (is_pressed[s]) begin
            if (hold_ticks[s] != HOLD_MAX) hold_ticks[s] = hold_ticks[s] + 16'd1;
            held = hold_ticks[s];
            // Thresholds that leave a gap keep the interval as it was.
            if (speeds_up) begin
                if (held > cfg_shadow.stage_one_start && held < cfg_shadow.stage_two_start)
                    repeat_ticks[s] = cfg_shadow.interval_one;
                else if (held >= cfg_shadow.stage_two_start &&
                         held < cfg_shadow.stage_three_start)
                    repeat_ticks[s] = cfg_shadow.interval_two;
                else if (held >= cfg_shadow.stage_three_start)
                    repeat_ticks[s] = cfg_shadow.interval_three;
            end
        end

        if (!repeat_due[s]) begin
            interval_cnt[s] = interval_cnt[s] + 16'd1;
            if (interval_cnt[s] >= repeat_ticks[s]) begin
                interval_cnt[s] = 16'd0;
                repeat_due[s]   = 1'b1;
            end
        end
    endtask

    // Register writes, tick prediction and status comparison, in that order.
    always @(posedge clk or negedge rst_n) begin : watch_channels
        button_status_t want;
        button_status_t got;
        logic [6:0] bad;
        if (!rst_n) begin
            cfg_shadow = CFG_RST;
            for (int s = 0; s < 3; s++) begin
                low_run_cnt[s]  = 8'd0;
                high_run_cnt[s] = 8'd0;
                is_pressed[s]   = 1'b0;
                hold_ticks[s]   = 16'd0;
                repeat_ticks[s] = INITIAL_INTERVAL_RST;
                interval_cnt[s] = 16'd0;
                repeat_due[s]   = 1'b0;
            end
            predicted_status_q.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS:    cfg_shadow.debounce_ticks    = cfg_data[7:0];
                    REG_INITIAL_INTERVAL:  cfg_shadow.initial_interval  = cfg_data;
                    REG_STAGE_ONE_START:   cfg_shadow.stage_one_start   = cfg_data;
                    REG_STAGE_TWO_START:   cfg_shadow.stage_two_start   = cfg_data;
                    REG_STAGE_THREE_START: cfg_shadow.stage_three_start = cfg_data;
                    REG_INTERVAL_ONE:      cfg_shadow.interval_one      = cfg_data;
                    REG_INTERVAL_TWO:      cfg_shadow.interval_two      = cfg_data;
                    REG_INTERVAL_THREE:    cfg_shadow.interval_three    = cfg_data;
                    default: ;
                endcase
            end

            // Acknowledges act before the tick; the pins are cross-wired to the slots.
            if (in_valid && in_ready) begin
                if (clear_inc)  repeat_due[SLOT_INC]  = 1'b0;
                if (clear_dec)  repeat_due[SLOT_DEC]  = 1'b0;
                if (clear_mode) repeat_due[SLOT_MODE] = 1'b0;
                advance_button(SLOT_MODE, pin_inc, 1'b0);
                advance_button(SLOT_DEC, pin_dec, 1'b1);
                advance_button(SLOT_INC, pin_mode, 1'b1);
                want.pressed_inc     = is_pressed[SLOT_INC];
                want.pressed_dec     = is_pressed[SLOT_DEC];
                want.pressed_mode    = is_pressed[SLOT_MODE];
                want.ready_inc       = repeat_due[SLOT_INC];
                want.ready_dec       = repeat_due[SLOT_DEC];
                want.ready_mode      = repeat_due[SLOT_MODE];
                want.mode_hold_ticks = hold_ticks[SLOT_MODE];
                predicted_status_q.push_back(want);
            end

            if (out_valid && out_ready) begin
                got.pressed_inc     = pressed_inc;
                got.pressed_dec     = pressed_dec;
                got.pressed_mode    = pressed_mode;
                got.ready_inc       = ready_inc;
                got.ready_dec       = ready_dec;
                got.ready_mode      = ready_mode;
                got.mode_hold_ticks = mode_hold_ticks;
                n_status++;
                if (predicted_status_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: status transfer %0d arrived with no tick pending",
                                 $realtime, n_status);
                end else begin
                    want = predicted_status_q.pop_front();
                    bad = {got.pressed_inc !== want.pressed_inc,
                           got.pressed_dec !== want.pressed_dec,
                           got.pressed_mode !== want.pressed_mode,
                           got.ready_inc !== want.ready_inc,
                           got.ready_dec !== want.ready_dec,
                           got.ready_mode !== want.ready_mode,
                           got.mode_hold_ticks !== want.mode_hold_ticks};
                    if (bad != 7'd0) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display("%0t: status %0d mismatch, fields %b ",
                                     $realtime, n_status, bad,
                                     "(pressed idm, ready idm, hold): expected %b%b%b %b%b%b %0d",
                                     want.pressed_inc, want.pressed_dec, want.pressed_mode,
                                     want.ready_inc, want.ready_dec, want.ready_mode,
                                     want.mode_hold_ticks,
                                     ", got %b%b%b %b%b%b %0d",
                                     got.pressed_inc, got.pressed_dec, got.pressed_mode,
                                     got.ready_inc, got.ready_dec, got.ready_mode,
                                     got.mode_hold_ticks);
                    end
                end
            end

            pending    <= predicted_status_q.size();
            fail_count <= n_fail;
        end
    end

endmodule

>>> dv/button_debounce_autorepeat_core_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for button_debounce_autorepeat_core: clock, reset, tick and
// register stimulus, status back-pressure, watchdog and verdict.
// Depends on bda_pkg, the core and bda_tick_checker.
module button_debounce_autorepeat_core_tb;
    import bda_pkg::*;

    localparam int RX_LONG_HOLD   = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_TICKS    = 120;
    localparam int SATURATE_TICKS = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic pin_inc = 1'b1;
    logic pin_dec = 1'b1;
    logic pin_mode = 1'b1;
    logic clear_inc = 1'b0;
    logic clear_dec = 1'b0;
    logic clear_mode = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic pressed_inc;
    logic pressed_dec;
    logic pressed_mode;
    logic ready_inc;
    logic ready_dec;
    logic ready_mode;
    logic [15:0] mode_hold_ticks;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int pending;
    int fail_count;

    // Idle control shared between the tick process and the status receiver.
    logic quiet_tail = 1'b0;
    int rx_gap_odds = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int rx_hold_left = 0;
    int rx_gap_left = 0;
    int tx_gap_odds = 0;
    int quiet_cycles = 0;

    // Pin waveform state, indexed pin_inc, pin_dec, pin_mode.
    logic pin_level [3] = '{1'b1, 1'b1, 1'b1};
    int run_left [3] = '{0, 0, 0};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    button_debounce_autorepeat_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pin_inc         (pin_inc),
        .pin_dec         (pin_dec),
        .pin_mode        (pin_mode),
        .clear_inc       (clear_inc),
        .clear_dec       (clear_dec),
        .clear_mode      (clear_mode),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pressed_inc     (pressed_inc),
        .pressed_dec     (pressed_dec),
        .pressed_mode    (pressed_mode),
        .ready_inc       (ready_inc),
        .ready_dec       (ready_dec),
        .ready_mode      (ready_mode),
        .mode_hold_ticks (mode_hold_ticks),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    bda_tick_checker status_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pin_inc         (pin_inc),
        .pin_dec         (pin_dec),
        .pin_mode        (pin_mode),
        .clear_inc       (clear_inc),
        .clear_dec       (clear_dec),
        .clear_mode      (clear_mode),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pressed_inc     (pressed_inc),
        .pressed_dec     (pressed_dec),
        .pressed_mode    (pressed_mode),
        .ready_inc       (ready_inc),
        .ready_dec       (ready_dec),
        .ready_mode      (ready_mode),
        .mode_hold_ticks (mode_hold_ticks),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    // Status receiver: a long hold-off on request, random stall bursts otherwise.
    always @(posedge clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            rx_hold_left = RX_LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            out_ready <= 1'b0;
        end else if (!quiet_tail && rx_gap_odds != 0 && $urandom_range(1, rx_gap_odds) == 1)
        begin
            rx_gap_left = $urandom_range(1, 12) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** button_debounce_autorepeat_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one tick and returns at the edge where it transfers; valid stays high.
    task automatic send_tick(input bda_item_t t);
        in_valid   <= 1'b1;
        pin_inc    <= t.pin_inc;
        pin_dec    <= t.pin_dec;
        pin_mode   <= t.pin_mode;
        clear_inc  <= t.clear_inc;
        clear_dec  <= t.clear_dec;
        clear_mode <= t.clear_mode;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Random sender gap before the next tick.
    task automatic maybe_pause();
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Stops offering ticks and waits until every predicted status has arrived.
    task automatic drain_status();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the whole register set; the debounce write sometimes carries junk above bit 7.
    task automatic program_cfg(input bda_cfg_t c);
        write_reg(REG_DEBOUNCE_TICKS,
                  {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, c.debounce_ticks});
        write_reg(REG_INITIAL_INTERVAL, c.initial_interval);
        write_reg(REG_STAGE_ONE_START, c.stage_one_start);
        write_reg(REG_STAGE_TWO_START, c.stage_two_start);
        write_reg(REG_STAGE_THREE_START, c.stage_three_start);
        write_reg(REG_INTERVAL_ONE, c.interval_one);
        write_reg(REG_INTERVAL_TWO, c.interval_two);
        write_reg(REG_INTERVAL_THREE, c.interval_three);
    endtask

    // Press and release waveforms with short bounces, some random noise ticks.
    task automatic make_item(input int max_run, output bda_item_t t);
        logic [2:0] lv;
        for (int p = 0; p < 3; p++) begin
            if (run_left[p] == 0) begin
                pin_level[p] = ~pin_level[p];
                run_left[p] = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2)
                                                          : $urandom_range(3, max_run);
            end
            run_left[p]--;
            lv[p] = pin_level[p];
        end
        if ($urandom_range(0, 19) == 0) lv = 3'($urandom);
        t.pin_inc    = lv[0];
        t.pin_dec    = lv[1];
        t.pin_mode   = lv[2];
        t.clear_inc  = ($urandom_range(0, 2) == 0);
        t.clear_dec  = ($urandom_range(0, 2) == 0);
        t.clear_mode = ($urandom_range(0, 2) == 0);
    endtask

    function automatic int pick_gap_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 16;
        endcase
    endfunction

    initial begin
        bda_cfg_t c;
        bda_item_t t;
        int run_max;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset register values: all high, all low, alternating.
        send_tick({3'b111, 3'b111});
        send_tick({3'b000, 3'b000});
        send_tick({3'b101, 3'b010});
        send_tick({3'b010, 3'b101});
        drain_status();

        // Zero debounce, a zero fastest interval and tight stages: press on the
        // first low sample, climb through all stages, release back to the initial interval.
        c = '{debounce_ticks: 8'd0, initial_interval: 16'd6, stage_one_start: 16'd2,
              stage_two_start: 16'd4, stage_three_start: 16'd7, interval_one: 16'd3,
              interval_two: 16'd1, interval_three: 16'd0};
        program_cfg(c);
        repeat (3) send_tick({3'b111, 3'b000});
        for (int k = 0; k < 9; k++) send_tick({3'b000, (k % 2 == 1) ? 3'b111 : 3'b000});
        repeat (3) send_tick({3'b111, 3'b111});
        send_tick({3'b001, 3'b100});
        send_tick({3'b110, 3'b011});
        drain_status();

        // Random phases, each on its own register setting and idle pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            c.debounce_ticks    = 8'($urandom_range(0, 6));
            c.initial_interval  = 16'($urandom_range(0, 12));
            c.stage_one_start   = 16'($urandom_range(0, 10));
            c.stage_two_start   = c.stage_one_start + 16'($urandom_range(0, 10));
            c.stage_three_start = c.stage_two_start + 16'($urandom_range(0, 15));
            // Sometimes misordered thresholds.
            if ($urandom_range(0, 3) == 0) begin
                c.stage_two_start   = 16'($urandom_range(0, 40));
                c.stage_three_start = 16'($urandom_range(0, 40));
            end
            c.interval_one   = 16'($urandom_range(0, 10));
            c.interval_two   = 16'($urandom_range(0, 10));
            c.interval_three = 16'($urandom_range(0, 10));
            program_cfg(c);

            run_max = $urandom_range(6, 45);
            tx_gap_odds = (ph == 0) ? 4 : pick_gap_odds();
            rx_gap_odds <= (ph == 0) ? 4 : pick_gap_odds();
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (ph == 2 && k == 40) hold_asks <= hold_asks + 1;
                make_item(run_max, t);
                maybe_pause();
                send_tick(t);
            end
            drain_status();
        end

        // Last part, full rate: longest debounce and initial interval, mode slot held long
        // enough for its low run counter to saturate and the press to be taken.
        quiet_tail <= 1'b1;
        tx_gap_odds = 0;
        c = '{debounce_ticks: 8'hFF, initial_interval: 16'hFFFF, stage_one_start: 16'h0000,
              stage_two_start: 16'hFFFF, stage_three_start: 16'hFFFF, interval_one: 16'h0001,
              interval_two: 16'hFFFF, interval_three: 16'hFFFF};
        program_cfg(c);
        for (int k = 0; k < SATURATE_TICKS; k++) begin
            make_item(400, t);
            t.pin_inc = 1'b0;
            send_tick(t);
        end
        drain_status();

        if (fail_count == 0)
            $display("** button_debounce_autorepeat_core: PASSED **");
        else
            $display("** button_debounce_autorepeat_core: FAILED **");
        $finish;
    end

endmodule
